// ===== sv/tpss_pkg.sv =====
package tpss_pkg;

  // Width of every coordinate and of the slice height (signed Q16.16).
  localparam int CoordW = 32;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CoordW-1:0] ucoord_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } tri_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  // A straddling triangle, reordered: the two vertices on the same side
  // in input order, then the lone vertex.
  typedef struct packed {
    vtx_t p0;
    vtx_t p1;
    vtx_t lone;
  } cls_t;

  // Operands of one interpolation lane.
  typedef struct packed {
    ucoord_t mag;
    ucoord_t num;
    ucoord_t den;
    coord_t  pc;
    logic    neg;
  } lane_t;

  // Quotient and remainder carried through the divider stages.
  typedef struct packed {
    ucoord_t q;
    ucoord_t r;
  } qr_t;

  // Magnitude of the difference of two signed values; it always fits CoordW bits.
  function automatic ucoord_t abs_diff(coord_t a, coord_t b);
    logic signed [CoordW:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    if (d[CoordW]) begin
      d = -d;
    end
    return d[CoordW-1:0];
  endfunction

  // One step of floor(mag * num / den): double the running value, then add num
  // if the next bit of mag is set, keeping the remainder below den.
  function automatic qr_t div_step(qr_t cur, logic bit_i, ucoord_t num, ucoord_t den);
    qr_t     nxt;
    ucoord_t gap;
    nxt = cur;
    gap = den - cur.r;
    if (cur.r >= gap) begin
      nxt.r = cur.r - gap;
      nxt.q = (cur.q << 1) + ucoord_t'(1);
    end else begin
      nxt.r = cur.r << 1;
      nxt.q = cur.q << 1;
    end
    if (bit_i) begin
      gap = den - num;
      if (nxt.r >= gap) begin
        nxt.r = nxt.r - gap;
        nxt.q = nxt.q + ucoord_t'(1);
      end else begin
        nxt.r = nxt.r + num;
      end
    end
    return nxt;
  endfunction

endpackage

// ===== sv/triangle_plane_slice_segment_core.sv =====
// Channel  Direction  Handshake                 Payload
// cfg      in         cfg_we_i                  cfg_data_i    (slice height)
// in       in         in_valid_i / in_stall_o   in_tri_i      (three vertices)
// out      out        out_valid_o / out_stall_i out_seg_o     (two crossings)
//
// One item is taken per cycle while the queue has room.
// A straddling triangle taken into an empty queue passes through one operand
// stage, CoordW divider stages and one result stage before out_valid_o rises.
// Triangles that do not straddle are taken and dropped without a result.
// Reset clears the queue, the valid chain and the slice height to zero.
// A stalled output freezes the whole back pipeline; the two-entry queue then
// fills, and the input stalls once it is full.
module triangle_plane_slice_segment_core
  import tpss_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cfg_we_i,
  input  coord_t cfg_data_i,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  tri_t   in_tri_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output seg_t   out_seg_o
);

  // Registers in the back pipeline: operand stage, divider stages, result stage.
  localparam int Lat = CoordW + 2;

  coord_t height_q;

  logic       hit;
  cls_t       cls;
  cls_t       head;
  logic       q_empty, q_full;
  logic [1:0] q_count;
  logic       push, pop, en;

  logic [Lat-1:0] vld_q, vld_d;
  lane_t          lane_q [4];
  coord_t         res [4];

  // The slice height register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= '0;
    end else if (cfg_we_i) begin
      height_q <= cfg_data_i;
    end
  end

  // Front: classify the triangle and queue only those that give a segment.
  tpss_front u_front (
    .tri_i    (in_tri_i),
    .height_i (height_q),
    .hit_o    (hit),
    .cls_o    (cls)
  );

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full && hit;

  tpss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  // Back: the whole pipeline advances together unless the output is held.
  assign en  = !(out_valid_o && out_stall_i);
  assign pop = en && !q_empty;

  assign vld_d = {vld_q[Lat-2:0], !q_empty};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Operand stage: distances along z give the fraction, distances in x and y
  // give the magnitudes to scale, one lane per output coordinate.
  always_ff @(posedge clk_i) begin
    if (en) begin
      lane_q[0] <= '{mag: abs_diff(head.lone.x, head.p0.x),
                     num: abs_diff(height_q, head.p0.z),
                     den: abs_diff(head.lone.z, head.p0.z),
                     pc: head.p0.x, neg: head.lone.x < head.p0.x};
      lane_q[1] <= '{mag: abs_diff(head.lone.y, head.p0.y),
                     num: abs_diff(height_q, head.p0.z),
                     den: abs_diff(head.lone.z, head.p0.z),
                     pc: head.p0.y, neg: head.lone.y < head.p0.y};
      lane_q[2] <= '{mag: abs_diff(head.lone.x, head.p1.x),
                     num: abs_diff(height_q, head.p1.z),
                     den: abs_diff(head.lone.z, head.p1.z),
                     pc: head.p1.x, neg: head.lone.x < head.p1.x};
      lane_q[3] <= '{mag: abs_diff(head.lone.y, head.p1.y),
                     num: abs_diff(height_q, head.p1.z),
                     den: abs_diff(head.lone.z, head.p1.z),
                     pc: head.p1.y, neg: head.lone.y < head.p1.y};
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    tpss_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (lane_q[k]),
      .res_o  (res[k])
    );
  end

  assign out_valid_o = vld_q[Lat-1];
  assign out_seg_o   = '{start_x: res[0], start_y: res[1], end_x: res[2], end_y: res[3]};

  // The queue never holds more than its two entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_count != 2'd3)
    else $error("queue count out of range");

  // A held output freezes the valid chain of the back pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("back pipeline moved while output held");

  // A straddling triangle that is taken lands in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && hit) |=> !q_empty)
    else $error("accepted segment item lost");

endmodule

// ===== sv/tpss_front.sv =====
module tpss_front
  import tpss_pkg::*;
(
  input  tri_t   tri_i,
  input  coord_t height_i,
  output logic   hit_o,
  output cls_t   cls_o
);

  vtx_t       va, vb, vc;
  logic [2:0] above, below;
  logic [1:0] n_above, n_below;
  logic       pair_above;

  assign va = '{x: tri_i.a_x, y: tri_i.a_y, z: tri_i.a_z};
  assign vb = '{x: tri_i.b_x, y: tri_i.b_y, z: tri_i.b_z};
  assign vc = '{x: tri_i.c_x, y: tri_i.c_y, z: tri_i.c_z};

  always_comb begin
    above = {tri_i.c_z > height_i, tri_i.b_z > height_i, tri_i.a_z > height_i};
    below = {tri_i.c_z < height_i, tri_i.b_z < height_i, tri_i.a_z < height_i};
    n_above = 2'(above[0]) + 2'(above[1]) + 2'(above[2]);
    n_below = 2'(below[0]) + 2'(below[1]) + 2'(below[2]);
    pair_above = (n_above == 2'd2);
    hit_o = ((n_above == 2'd2) && (n_below == 2'd1)) ||
            ((n_below == 2'd2) && (n_above == 2'd1));
    // The lone vertex is the one whose side differs from the pair's side.
    if (above[0] != pair_above) begin
      cls_o = '{p0: vb, p1: vc, lone: va};
    end else if (above[1] != pair_above) begin
      cls_o = '{p0: va, p1: vc, lone: vb};
    end else begin
      cls_o = '{p0: va, p1: vb, lone: vc};
    end
  end

endmodule

// ===== sv/tpss_queue.sv =====
module tpss_queue
  import tpss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cls_t       data_i,
  input  logic       pop_i,
  output cls_t       data_o,
  output logic       empty_o,
  output logic       full_o,
  output logic [1:0] count_o
);

  cls_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/tpss_lane.sv =====
module tpss_lane
  import tpss_pkg::*;
(
  input  logic   clk_i,
  input  logic   en_i,
  input  lane_t  lane_i,
  output coord_t res_o
);

  lane_t  op_q [1:CoordW];
  qr_t    qr_q [1:CoordW];
  coord_t res_q;

  // One register stage per bit of the magnitude, most significant bit first.
  for (genvar s = 0; s < CoordW; s++) begin : g_stage
    lane_t op_in;
    qr_t   qr_in;
    if (s == 0) begin : g_first
      assign op_in = lane_i;
      assign qr_in = '0;
    end else begin : g_next
      assign op_in = op_q[s];
      assign qr_in = qr_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        op_q[s+1] <= op_in;
        qr_q[s+1] <= div_step(qr_in, op_in.mag[CoordW-1-s], op_in.num, op_in.den);
      end
    end
  end

  // The offset moves from the paired vertex toward the lone one.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= op_q[CoordW].neg ? op_q[CoordW].pc - coord_t'(qr_q[CoordW].q)
                                : op_q[CoordW].pc + coord_t'(qr_q[CoordW].q);
    end
  end

  assign res_o = res_q;

endmodule
